// ===== design/ntc_pkg.sv =====
// package: constants, types and resistance table for the ntc lookup
package ntc_pkg;

    localparam int TABLE_ENTRIES = 166;
    localparam int IDX_W         = 8;
    localparam int CODE_W        = 12;
    localparam int MV_W          = 12;
    localparam int NUM_W         = 26;
    localparam int QUO_W         = 26;
    localparam int RES_W         = 29;
    localparam int DEN_W         = 12;
    localparam int TAB_W         = 21;

    localparam logic [MV_W-1:0]  VREF_MV  = 12'd3300;
    localparam logic [13:0]      SERIES_R = 14'd10900;

    typedef logic [TAB_W-1:0] tab_t;

    typedef struct packed {
        logic [CODE_W-1:0] adc_code;
    } in_item_t;

    typedef struct packed {
        logic [RES_W-1:0] resistance;
        logic [IDX_W-1:0] temp_index;
    } out_item_t;

    function automatic tab_t ntc_entry(input logic [IDX_W-1:0] i);
        tab_t t [0:165];
        t = '{
            21'd1956520, 21'd1849171, 21'd1748452, 21'd1653910, 21'd1565125,
            21'd1481710, 21'd1403304, 21'd1329576, 21'd1260215, 21'd1194936,
            21'd1133471, 21'd1075649, 21'd1021155, 21'd969776, 21'd921315,
            21'd875588, 21'd832424, 21'd791663, 21'd753157, 21'd716768,
            21'd682367, 21'd649907, 21'd619190, 21'd590113, 21'd562579,
            21'd536496, 21'd511779, 21'd488349, 21'd466132, 21'd445058,
            21'd425062, 21'd405997, 21'd387905, 21'd370729, 21'd354417,
            21'd338922, 21'd324197, 21'd310200, 21'd296890, 21'd284231,
            21'd272186, 21'd260760, 21'd249877, 21'd239509, 21'd229629,
            21'd220211, 21'd211230, 21'd202666, 21'd194495, 21'd186698,
            21'd179255, 21'd172139, 21'd165344, 21'd158856, 21'd152658,
            21'd146735, 21'd141075, 21'd135664, 21'd130489, 21'd125540,
            21'd120805, 21'd116281, 21'd111947, 21'd107795, 21'd103815,
            21'd100000, 21'd96342, 21'd92835, 21'd89470, 21'd86242,
            21'd83145, 21'd80181, 21'd77337, 21'd74609, 21'd71991,
            21'd69479, 21'd67067, 21'd64751, 21'd62526, 21'd60390,
            21'd58336, 21'd56357, 21'd54454, 21'd52623, 21'd50863,
            21'd49169, 21'd47539, 21'd45971, 21'd44461, 21'd43008,
            21'd41609, 21'd40262, 21'd38964, 21'd37714, 21'd36510,
            21'd35350, 21'd34231, 21'd33152, 21'd32113, 21'd31110,
            21'd30143, 21'd29224, 21'd28337, 21'd27482, 21'd26657,
            21'd25861, 21'd25093, 21'd24351, 21'd23635, 21'd22943,
            21'd22275, 21'd21627, 21'd21001, 21'd20396, 21'd19811,
            21'd19245, 21'd18698, 21'd18170, 21'd17658, 21'd17164,
            21'd16685, 21'd16224, 21'd15777, 21'd15345, 21'd14927,
            21'd14521, 21'd14129, 21'd13749, 21'd13381, 21'd13025,
            21'd12680, 21'd12343, 21'd12016, 21'd11700, 21'd11393,
            21'd11096, 21'd10807, 21'd10528, 21'd10256, 21'd9993,
            21'd9738, 21'd9492, 21'd9254, 21'd9022, 21'd8798,
            21'd8580, 21'd8368, 21'd8162, 21'd7963, 21'd7769,
            21'd7580, 21'd7397, 21'd7219, 21'd7046, 21'd6878,
            21'd6715, 21'd6556, 21'd6402, 21'd6252, 21'd6106,
            21'd5964, 21'd5826, 21'd5692, 21'd5562, 21'd5435,
            21'd5311
        };
        if (i > 8'd165)
        begin
            return '0;
        end
        return t[i];
    endfunction

endpackage

// ===== design/ntc_if.sv =====
// valid/ready channel interface carrying one item
interface ntc_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ntc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ntc_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ntc_pkg::NUM_W-1:0]         num,
    input  logic [ntc_pkg::DEN_W-1:0]         den,
    output logic                              out_valid,
    output logic [ntc_pkg::QUO_W-1:0]         quo
);
    localparam int N = ntc_pkg::NUM_W;
    localparam int D = ntc_pkg::DEN_W;

    logic [N:0]       v_reg   ;
    logic [N-1:0]     q_reg   [0:N];
    logic [D-1:0]     rem_reg [0:N];
    logic [D-1:0]     d_reg   [0:N];
    logic [N-1:0]     n_reg   [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= num;
            d_reg[0]   <= den;
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [D:0]   trial;
        logic [D:0]   diff;
        always_comb
        begin
            trial = {rem_reg[s], n_reg[s][N-1-s]};
            diff  = trial - {1'b0, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s];
                d_reg[s+1] <= d_reg[s];
                if (!diff[D])
                begin
                    rem_reg[s+1] <= diff[D-1:0];
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= trial[D-1:0];
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quo       = q_reg[N];
endmodule

// ===== design/ntc_search.sv =====
// parallel table compare and registered index encoder
module ntc_search
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ntc_pkg::RES_W-1:0]         res_in,
    output logic                              out_valid,
    output ntc_pkg::out_item_t                item
);
    localparam int E = ntc_pkg::TABLE_ENTRIES;

    logic [E-1:0]              ge_reg;
    logic [ntc_pkg::RES_W-1:0] r_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    ntc_pkg::out_item_t        item_reg;
    logic [E-1:0]              ge_next;
    logic [ntc_pkg::IDX_W-1:0] idx_next;

    always_comb
    begin
        for (int i = 0; i < E; i++)
        begin
            ge_next[i] = res_in >= {8'd0, ntc_pkg::ntc_entry(ntc_pkg::IDX_W'(i))};
        end
    end

    // first index i with r >= table[i+1]; table falls so ge bits are thermometer
    always_comb
    begin
        idx_next = ntc_pkg::IDX_W'(E - 1);
        for (int i = E - 2; i >= 0; i--)
        begin
            if (ge_reg[i+1])
            begin
                idx_next = ntc_pkg::IDX_W'(i);
            end
        end
        if (ge_reg[0])
        begin
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ge_reg              <= ge_next;
            r_reg               <= res_in;
            item_reg.resistance <= r_reg;
            item_reg.temp_index <= idx_next;
        end
    end

    assign out_valid = v2_reg;
    assign item      = item_reg;
endmodule

// ===== design/ntc_adc_to_temperature_index_top.sv =====
// top level: ntc adc code to resistance and temperature index
// usage:
//   in  channel carries adc_code; out channel carries resistance, temp_index
//   an item is accepted when valid and ready are both high
//   the pipeline accepts one item per cycle, back to back, while the receiver does not stall
//   the path from input accept to output valid has 33 register stages:
//   product, millivolt and divider operand registers (3 stages),
//   divider input register plus 26 quotient stages, scale, compare, encode
//   the divider depth (one quotient bit per stage) sets the latency
//   when the receiver stalls with a result waiting, the whole pipeline holds;
//   input ready is low only then, so nothing is lost or repeated
//   reset clears all valid bits; payload registers are not reset
//   results leave in the order the codes entered
module ntc_adc_to_temperature_index_top
(
    input  logic clk,
    input  logic rst_n,
    ntc_if.sink   in_ch,
    ntc_if.source out_ch
);
    logic                         en;
    logic                         s_valid;
    ntc_pkg::out_item_t           s_item;

    logic                         v0_reg, v1_reg, v2_reg;
    logic [23:0]                  prod_reg;
    logic [ntc_pkg::MV_W-1:0]     mv_reg;
    logic [ntc_pkg::NUM_W-1:0]    num_reg;
    logic [ntc_pkg::DEN_W-1:0]    den_reg;
    logic                         dv;
    logic [ntc_pkg::QUO_W-1:0]    quo;
    logic                         rv_reg;
    logic [ntc_pkg::RES_W-1:0]    r_reg;

    assign en          = !s_valid || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = s_valid;
    assign out_ch.data  = s_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            rv_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 24'(in_ch.data.adc_code * ntc_pkg::VREF_MV);
            mv_reg   <= prod_reg[23:12];
            num_reg  <= ntc_pkg::NUM_W'(mv_reg * ntc_pkg::SERIES_R);
            den_reg  <= ntc_pkg::VREF_MV - mv_reg;
            r_reg    <= ntc_pkg::RES_W'({quo, 3'b000} + {2'b00, quo, 1'b0});
        end
    end

    ntc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .num      (num_reg),
        .den      (den_reg),
        .out_valid(dv),
        .quo      (quo)
    );

    ntc_search u_search
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (rv_reg),
        .res_in   (r_reg),
        .out_valid(s_valid),
        .item     (s_item)
    );
endmodule
